// File: hw/rtl/ssc_pkg.sv
package ssc_pkg;

	localparam int WORD_WIDTH = 32;
	localparam int RADIUS_W   = 20;
	localparam int CFG_W      = 32;
	localparam int CFG_FRAC   = 8;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_SPRING  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_DAMPING = 1'b1;

	localparam logic [CFG_W-1:0] STIFF_RESET = 32'd256000;
	localparam logic [CFG_W-1:0] DAMP_RESET  = 32'd0;

	typedef struct packed {
		logic signed [WORD_WIDTH-1:0] first_x;
		logic signed [WORD_WIDTH-1:0] first_y;
		logic signed [WORD_WIDTH-1:0] second_x;
		logic signed [WORD_WIDTH-1:0] second_y;
		logic signed [WORD_WIDTH-1:0] first_vx;
		logic signed [WORD_WIDTH-1:0] first_vy;
		logic signed [WORD_WIDTH-1:0] second_vx;
		logic signed [WORD_WIDTH-1:0] second_vy;
		logic        [RADIUS_W-1:0]   first_radius;
		logic        [RADIUS_W-1:0]   second_radius;
	} pair_t;

	typedef struct packed {
		logic signed [WORD_WIDTH-1:0] force_x;
		logic signed [WORD_WIDTH-1:0] force_y;
		logic                         in_contact;
		logic                         coincident;
	} reaction_t;

endpackage

// File: hw/rtl/soft_sphere_contact_force_top.sv
// throughput: one pair per cycle while the output is not stalled;
// a 22-step square root and a 53-step divider, two steps per stage but
// one in the last divider stage, set the depth
// stalls collapse bubbles stage by stage, the output register holds the result
// reset clears all stage valid bits and loads the stiffness and damping defaults
module soft_sphere_contact_force_top import ssc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pair_valid,
	output logic                 pair_stall,
	input  pair_t                pair,
	output logic                 reaction_valid,
	input  logic                 reaction_stall,
	output reaction_t            reaction,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int DIFF_W  = WORD_WIDTH + 1;
	localparam int MAG_W   = RADIUS_W + 1;
	localparam int D2_W    = 2 * MAG_W + 1;
	localparam int ROOT_W  = (D2_W + 1) / 2;
	localparam int RAD_W   = 2 * ROOT_W;
	localparam int SREM_W  = ROOT_W + 4;
	localparam int SQ_ST   = ROOT_W / 2;
	localparam int P_W     = 2 * MAG_W;
	localparam int HALF_W  = CFG_W / 2;
	localparam int PP_W    = P_W + HALF_W;
	localparam int N_W     = P_W + CFG_W;
	localparam int Q_W     = MAG_W + CFG_W;
	localparam int DIV_ST  = (Q_W + 1) / 2;
	localparam int DAMP_W  = CFG_W + DIFF_W - CFG_FRAC;
	localparam int SPR_W   = Q_W - CFG_FRAC;
	localparam int SUM_W   = DAMP_W + 2;

	localparam int ST_OVL  = SQ_ST + 2;
	localparam int ST_M1   = ST_OVL + 1;
	localparam int ST_M2   = ST_M1 + 1;
	localparam int ST_DV0  = ST_M2 + 1;
	localparam int ST_OUT  = ST_DV0 + DIV_ST + 1;
	localparam int NS      = ST_OUT + 1;

	localparam logic signed [DIFF_W-1:0] REACH = DIFF_W'(64'sd1 <<< MAG_W);
	localparam logic signed [SUM_W-1:0] SAT_HI =
		SUM_W'((64'sd1 <<< (WORD_WIDTH - 1)) - 64'sd1);
	localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

	typedef struct packed {
		logic [MAG_W-1:0]  ax;
		logic [MAG_W-1:0]  ay;
		logic [MAG_W-1:0]  rsum;
		logic              near;
		logic              coinc;
		logic              xneg;
		logic              yneg;
		logic              vxneg;
		logic              vyneg;
		logic [DIFF_W-1:0] avx;
		logic [DIFF_W-1:0] avy;
	} pre_t;

	typedef struct packed {
		logic              coinc;
		logic              contact;
		logic              xneg;
		logic              yneg;
		logic              vxneg;
		logic              vyneg;
		logic [DAMP_W-1:0] dmx;
		logic [DAMP_W-1:0] dmy;
	} tail_t;

	typedef struct packed {
		logic [RAD_W-1:0]  rad;
		logic [SREM_W-1:0] rem;
		logic [ROOT_W-1:0] root;
		logic [MAG_W-1:0]  ax;
		logic [MAG_W-1:0]  ay;
		logic [MAG_W-1:0]  rsum;
		logic              near;
	} sq_t;

	typedef struct packed {
		logic [MAG_W-1:0]  ovl;
		logic [MAG_W-1:0]  ax;
		logic [MAG_W-1:0]  ay;
		logic [ROOT_W-1:0] dlen;
	} ov_t;

	typedef struct packed {
		logic [P_W-1:0]    px;
		logic [P_W-1:0]    py;
		logic [ROOT_W-1:0] dlen;
	} m1_t;

	typedef struct packed {
		logic [PP_W-1:0]   pxl;
		logic [PP_W-1:0]   pxh;
		logic [PP_W-1:0]   pyl;
		logic [PP_W-1:0]   pyh;
		logic [ROOT_W-1:0] dlen;
	} m2_t;

	typedef struct packed {
		logic [ROOT_W-1:0] rem;
		logic [Q_W-1:0]    num;
	} lane_t;

	typedef struct packed {
		lane_t             x;
		lane_t             y;
		logic [ROOT_W-1:0] dlen;
	} dv_t;

	function automatic sq_t sq_step(sq_t s);
		sq_t               n;
		logic [SREM_W-1:0] r;
		logic [SREM_W-1:0] t;
		n = s;
		r = {s.rem[SREM_W-3:0], s.rad[RAD_W-1 -: 2]};
		t = SREM_W'({s.root, 2'b01});
		if (r >= t) begin
			n.rem  = r - t;
			n.root = {s.root[ROOT_W-2:0], 1'b1};
		end else begin
			n.rem  = r;
			n.root = {s.root[ROOT_W-2:0], 1'b0};
		end
		n.rad = {s.rad[RAD_W-3:0], 2'b00};
		return n;
	endfunction

	function automatic lane_t div_step(lane_t l, logic [ROOT_W-1:0] d);
		lane_t           n;
		logic [ROOT_W:0] r;
		logic            qb;
		r  = {l.rem, l.num[Q_W-1]};
		qb = (r >= {1'b0, d});
		n.rem = qb ? ROOT_W'(r - {1'b0, d}) : r[ROOT_W-1:0];
		n.num = {l.num[Q_W-2:0], qb};
		return n;
	endfunction

	function automatic logic signed [WORD_WIDTH-1:0] sat(logic signed [SUM_W-1:0] v);
		logic signed [WORD_WIDTH-1:0] r;
		if (v > SAT_HI)
			r = SAT_HI[WORD_WIDTH-1:0];
		else if (v < SAT_LO)
			r = SAT_LO[WORD_WIDTH-1:0];
		else
			r = v[WORD_WIDTH-1:0];
		return r;
	endfunction

	logic [CFG_W-1:0] stiff_q;
	logic [CFG_W-1:0] damp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stiff_q <= STIFF_RESET;
			damp_q  <= DAMP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SPRING:  stiff_q <= cfg_data;
				CFG_DAMPING: damp_q  <= cfg_data;
			endcase
		end
	end

	// valid chain, a stage loads when empty or when the next one loads
	logic [NS-1:0] vld_s;
	logic [NS:0]   ld;

	assign ld[NS] = !reaction_stall;
	for (genvar k = 0; k < NS; k++) begin : g_ld
		assign ld[k] = !vld_s[k] || ld[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (ld[0])
				vld_s[0] <= pair_valid;
			for (int k = 1; k < NS; k++) begin
				if (ld[k])
					vld_s[k] <= vld_s[k-1];
			end
		end
	end

	assign pair_stall = !ld[0];

	// stage 1: differences and magnitudes
	logic signed [DIFF_W-1:0] dx_c, dy_c, dvx_c, dvy_c;
	logic        [DIFF_W-1:0] adx_c, ady_c;
	pre_t                     pre_c;
	pre_t                     pre_s1;

	always_comb begin
		dx_c  = DIFF_W'(pair.second_x) - DIFF_W'(pair.first_x);
		dy_c  = DIFF_W'(pair.second_y) - DIFF_W'(pair.first_y);
		dvx_c = DIFF_W'(pair.second_vx) - DIFF_W'(pair.first_vx);
		dvy_c = DIFF_W'(pair.second_vy) - DIFF_W'(pair.first_vy);
		adx_c = dx_c[DIFF_W-1] ? DIFF_W'(-dx_c) : DIFF_W'(dx_c);
		ady_c = dy_c[DIFF_W-1] ? DIFF_W'(-dy_c) : DIFF_W'(dy_c);
		pre_c.ax    = adx_c[MAG_W-1:0];
		pre_c.ay    = ady_c[MAG_W-1:0];
		pre_c.rsum  = MAG_W'(pair.first_radius) + MAG_W'(pair.second_radius);
		pre_c.near  = (dx_c > -REACH) && (dx_c < REACH) && (dy_c > -REACH) && (dy_c < REACH);
		pre_c.coinc = pre_c.near && (dx_c == '0) && (dy_c == '0);
		pre_c.xneg  = dx_c[DIFF_W-1];
		pre_c.yneg  = dy_c[DIFF_W-1];
		pre_c.vxneg = dvx_c[DIFF_W-1];
		pre_c.vyneg = dvy_c[DIFF_W-1];
		pre_c.avx   = dvx_c[DIFF_W-1] ? DIFF_W'(-dvx_c) : DIFF_W'(dvx_c);
		pre_c.avy   = dvy_c[DIFF_W-1] ? DIFF_W'(-dvy_c) : DIFF_W'(dvy_c);
	end

	always_ff @(posedge clk) begin
		if (ld[0])
			pre_s1 <= pre_c;
	end

	// stage 2: squared distance and damping products
	tail_t tl_s [1:NS-2];
	sq_t   sq_s [0:SQ_ST];

	logic [CFG_W+DIFF_W-1:0] pvx_c, pvy_c;
	logic [D2_W-1:0]         d2_c;

	always_comb begin
		pvx_c = damp_q * pre_s1.avx;
		pvy_c = damp_q * pre_s1.avy;
		d2_c  = D2_W'(pre_s1.ax) * D2_W'(pre_s1.ax) + D2_W'(pre_s1.ay) * D2_W'(pre_s1.ay);
	end

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			tl_s[1].coinc   <= pre_s1.coinc;
			tl_s[1].contact <= 1'b0;
			tl_s[1].xneg    <= pre_s1.xneg;
			tl_s[1].yneg    <= pre_s1.yneg;
			tl_s[1].vxneg   <= pre_s1.vxneg;
			tl_s[1].vyneg   <= pre_s1.vyneg;
			tl_s[1].dmx     <= pvx_c[CFG_W+DIFF_W-1:CFG_FRAC];
			tl_s[1].dmy     <= pvy_c[CFG_W+DIFF_W-1:CFG_FRAC];
			sq_s[0].rad     <= RAD_W'(d2_c);
			sq_s[0].rem     <= '0;
			sq_s[0].root    <= '0;
			sq_s[0].ax      <= pre_s1.ax;
			sq_s[0].ay      <= pre_s1.ay;
			sq_s[0].rsum    <= pre_s1.rsum;
			sq_s[0].near    <= pre_s1.near;
		end
	end

	// square root, two result bits per stage
	for (genvar j = 1; j <= SQ_ST; j++) begin : g_sq
		always_ff @(posedge clk) begin
			if (ld[1+j])
				sq_s[j] <= sq_step(sq_step(sq_s[j-1]));
		end
	end

	for (genvar k = 2; k <= NS - 2; k++) begin : g_tail
		if (k == ST_OVL) begin : g_ovl
			tail_t ovl_tail_c;

			always_comb begin
				ovl_tail_c         = tl_s[k-1];
				ovl_tail_c.contact = sq_s[SQ_ST].near &&
					({1'b0, sq_s[SQ_ST].rsum} > sq_s[SQ_ST].root);
			end

			always_ff @(posedge clk) begin
				if (ld[k])
					tl_s[k] <= ovl_tail_c;
			end
		end else begin : g_pass
			always_ff @(posedge clk) begin
				if (ld[k])
					tl_s[k] <= tl_s[k-1];
			end
		end
	end

	// overlap, then overlap times separation, then times stiffness in halves
	ov_t ov_s;
	m1_t m1_s;
	m2_t m2_s;
	dv_t dv_s [0:DIV_ST];

	logic [N_W-1:0] nx_c, ny_c;

	always_comb begin
		nx_c = N_W'(m2_s.pxl) + {m2_s.pxh, {HALF_W{1'b0}}};
		ny_c = N_W'(m2_s.pyl) + {m2_s.pyh, {HALF_W{1'b0}}};
	end

	always_ff @(posedge clk) begin
		if (ld[ST_OVL]) begin
			ov_s.ovl  <= MAG_W'({1'b0, sq_s[SQ_ST].rsum} - sq_s[SQ_ST].root);
			ov_s.ax   <= sq_s[SQ_ST].ax;
			ov_s.ay   <= sq_s[SQ_ST].ay;
			ov_s.dlen <= sq_s[SQ_ST].root;
		end
		if (ld[ST_M1]) begin
			m1_s.px   <= ov_s.ovl * ov_s.ax;
			m1_s.py   <= ov_s.ovl * ov_s.ay;
			m1_s.dlen <= ov_s.dlen;
		end
		if (ld[ST_M2]) begin
			m2_s.pxl  <= m1_s.px * stiff_q[HALF_W-1:0];
			m2_s.pxh  <= m1_s.px * stiff_q[CFG_W-1:HALF_W];
			m2_s.pyl  <= m1_s.py * stiff_q[HALF_W-1:0];
			m2_s.pyh  <= m1_s.py * stiff_q[CFG_W-1:HALF_W];
			m2_s.dlen <= m1_s.dlen;
		end
		// top bits of the dividend already sit below the divisor under contact
		if (ld[ST_DV0]) begin
			dv_s[0].x.rem <= ROOT_W'(nx_c[N_W-1:Q_W]);
			dv_s[0].x.num <= nx_c[Q_W-1:0];
			dv_s[0].y.rem <= ROOT_W'(ny_c[N_W-1:Q_W]);
			dv_s[0].y.num <= ny_c[Q_W-1:0];
			dv_s[0].dlen  <= m2_s.dlen;
		end
	end

	// restoring divider, two quotient bits per stage, one in the last
	for (genvar j = 1; j <= DIV_ST; j++) begin : g_div
		if (2 * j <= Q_W) begin : g_two
			always_ff @(posedge clk) begin
				if (ld[ST_DV0+j]) begin
					dv_s[j].x    <= div_step(div_step(dv_s[j-1].x, dv_s[j-1].dlen),
						dv_s[j-1].dlen);
					dv_s[j].y    <= div_step(div_step(dv_s[j-1].y, dv_s[j-1].dlen),
						dv_s[j-1].dlen);
					dv_s[j].dlen <= dv_s[j-1].dlen;
				end
			end
		end else begin : g_one
			always_ff @(posedge clk) begin
				if (ld[ST_DV0+j]) begin
					dv_s[j].x    <= div_step(dv_s[j-1].x, dv_s[j-1].dlen);
					dv_s[j].y    <= div_step(dv_s[j-1].y, dv_s[j-1].dlen);
					dv_s[j].dlen <= dv_s[j-1].dlen;
				end
			end
		end
	end

	// final stage: signs, sum and saturation
	tail_t                    tl_last;
	logic        [SPR_W-1:0]  smx_c, smy_c;
	logic signed [SPR_W:0]    spx_c, spy_c;
	logic signed [DAMP_W:0]   dpx_c, dpy_c;
	logic signed [SUM_W-1:0]  sumx_c, sumy_c;
	reaction_t                res_c;
	reaction_t                res_s45;

	always_comb begin
		tl_last = tl_s[NS-2];
		smx_c = dv_s[DIV_ST].x.num[Q_W-1:CFG_FRAC];
		smy_c = dv_s[DIV_ST].y.num[Q_W-1:CFG_FRAC];
		spx_c = tl_last.xneg ? $signed({1'b0, smx_c}) : -$signed({1'b0, smx_c});
		spy_c = tl_last.yneg ? $signed({1'b0, smy_c}) : -$signed({1'b0, smy_c});
		if (tl_last.coinc) begin
			spx_c = '0;
			spy_c = '0;
		end
		dpx_c  = tl_last.vxneg ? -$signed({1'b0, tl_last.dmx}) : $signed({1'b0, tl_last.dmx});
		dpy_c  = tl_last.vyneg ? -$signed({1'b0, tl_last.dmy}) : $signed({1'b0, tl_last.dmy});
		sumx_c = SUM_W'(dpx_c) + SUM_W'(spx_c);
		sumy_c = SUM_W'(dpy_c) + SUM_W'(spy_c);
		res_c.force_x    = tl_last.contact ? sat(sumx_c) : '0;
		res_c.force_y    = tl_last.contact ? sat(sumy_c) : '0;
		res_c.in_contact = tl_last.contact;
		res_c.coincident = tl_last.coinc;
	end

	always_ff @(posedge clk) begin
		if (ld[ST_OUT])
			res_s45 <= res_c;
	end

	assign reaction_valid = vld_s[ST_OUT];
	assign reaction       = res_s45;

`ifndef SYNTHESIS
	// a pair is held off only when every stage holds an item
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		pair_stall |-> (&vld_s))
		else $error("pair stalled with a free stage");

	a_no_contact_zero: assert property (@(posedge clk) disable iff (!arst_n)
		reaction_valid && !reaction.in_contact |->
			(reaction.force_x == '0) && (reaction.force_y == '0))
		else $error("force without contact");

	// under contact with separate centres the divider remainder must stay below the distance
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[NS-2] && tl_s[NS-2].contact && !tl_s[NS-2].coinc |->
			(dv_s[DIV_ST].x.rem < dv_s[DIV_ST].dlen) &&
			(dv_s[DIV_ST].y.rem < dv_s[DIV_ST].dlen))
		else $error("divider remainder out of range");
`endif

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import ssc_pkg::*;

	localparam int LATENCY     = 45;
	localparam int CYCLE_LIMIT = 400000;
	localparam longint FORCE_MAX = 64'sd2147483647;
	localparam longint FORCE_MIN = -64'sd2147483648;
	localparam longint REACH     = 64'sd2097152;

	logic                 clk;
	logic                 arst_n;
	logic                 pair_valid;
	logic                 pair_stall;
	pair_t                pair;
	logic                 reaction_valid;
	logic                 reaction_stall;
	reaction_t            reaction;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	logic [CFG_W-1:0] stiffness_k;
	logic [CFG_W-1:0] damping_k;
	reaction_t        expected_reactions[$];
	int               sender_idle_pct;
	int               receiver_stall_pct;
	int               mismatches;
	int               pairs_sent;
	int               reactions_seen;
	int               contacts_seen;
	int               cycles;

	soft_sphere_contact_force_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.pair_valid(pair_valid),
		.pair_stall(pair_stall),
		.pair(pair),
		.reaction_valid(reaction_valid),
		.reaction_stall(reaction_stall),
		.reaction(reaction),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned root = 0;
		longint unsigned probe = 64'h1 << 62;
		while (probe > v)
			probe >>= 2;
		while (probe != 0) begin
			if (v >= root + probe) begin
				v -= root + probe;
				root = (root >> 1) + probe;
			end else begin
				root >>= 1;
			end
			probe >>= 2;
		end
		return root;
	endfunction

	// exact floor of q*|d|/dlen without overflow, shifted down by CFG_FRAC, sign opposite to d
	function automatic longint spring_share(longint unsigned q, longint d, longint unsigned dlen);
		longint unsigned mag;
		longint unsigned m;
		mag = (d < 0) ? longint'(-d) : longint'(d);
		m = (q / dlen) * mag + ((q % dlen) * mag) / dlen;
		m >>= CFG_FRAC;
		return (d > 0) ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint damping_share(longint dv);
		longint unsigned mag;
		longint unsigned m;
		longint unsigned coeff;
		coeff = damping_k;
		mag = (dv < 0) ? longint'(-dv) : longint'(dv);
		m = (coeff * mag) >> CFG_FRAC;
		return (dv < 0) ? -longint'(m) : longint'(m);
	endfunction

	function automatic logic [WORD_WIDTH-1:0] clamp_force(longint f);
		if (f > FORCE_MAX)
			f = FORCE_MAX;
		if (f < FORCE_MIN)
			f = FORCE_MIN;
		return f[WORD_WIDTH-1:0];
	endfunction

	function automatic reaction_t predict_reaction(pair_t p);
		longint dx, dy, dvx, dvy, fx, fy;
		longint unsigned rsum, sq, dlen, q, coeff;
		reaction_t r;
		dx = longint'(p.second_x) - longint'(p.first_x);
		dy = longint'(p.second_y) - longint'(p.first_y);
		dvx = longint'(p.second_vx) - longint'(p.first_vx);
		dvy = longint'(p.second_vy) - longint'(p.first_vy);
		rsum = longint'(p.first_radius) + longint'(p.second_radius);
		fx = 0;
		fy = 0;
		r = '0;
		if (dx > -REACH && dx < REACH && dy > -REACH && dy < REACH) begin
			sq = dx * dx + dy * dy;
			dlen = floor_sqrt(sq);
			r.coincident = (sq == 0);
			if (rsum > dlen) begin
				coeff = stiffness_k;
				q = (rsum - dlen) * coeff;
				r.in_contact = 1'b1;
				fx = damping_share(dvx);
				fy = damping_share(dvy);
				if (sq != 0) begin
					fx += spring_share(q, dx, dlen);
					fy += spring_share(q, dy, dlen);
				end
			end
		end
		r.force_x = clamp_force(fx);
		r.force_y = clamp_force(fy);
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [WORD_WIDTH-1:0] got,
			logic [WORD_WIDTH-1:0] want);
		mismatches++;
		$display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(negedge clk)
		reaction_stall <= ($urandom_range(99) < receiver_stall_pct);

	always @(posedge clk) begin
		reaction_t want;
		if (arst_n && reaction_valid && !reaction_stall) begin
			reactions_seen++;
			if (expected_reactions.size() == 0) begin
				report_mismatch("unexpected transfer", reaction.force_x, '0);
			end else begin
				want = expected_reactions.pop_front();
				if (want.in_contact)
					contacts_seen++;
				if (reaction.force_x !== want.force_x)
					report_mismatch("force_x", reaction.force_x, want.force_x);
				if (reaction.force_y !== want.force_y)
					report_mismatch("force_y", reaction.force_y, want.force_y);
				if (reaction.in_contact !== want.in_contact)
					report_mismatch("in_contact", reaction.in_contact, want.in_contact);
				if (reaction.coincident !== want.coincident)
					report_mismatch("coincident", reaction.coincident, want.coincident);
			end
		end
	end

	// called just after a falling edge, returns just after a falling edge
	task automatic send_pair(pair_t p);
		while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
			pair_valid = 1'b0;
			@(negedge clk);
		end
		pair = p;
		pair_valid = 1'b1;
		do
			@(posedge clk);
		while (pair_stall);
		expected_reactions.push_back(predict_reaction(p));
		pairs_sent++;
		@(negedge clk);
		pair_valid = 1'b0;
	endtask

	task automatic wait_idle();
		while (expected_reactions.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == CFG_SPRING)
			stiffness_k = value;
		else if (idx == CFG_DAMPING)
			damping_k = value;
	endtask

	task automatic set_coefficients(logic [CFG_W-1:0] k, logic [CFG_W-1:0] b);
		wait_idle();
		write_reg(CFG_SPRING, k);
		write_reg(CFG_DAMPING, b);
	endtask

	function automatic pair_t make_pair(int x1, int y1, int x2, int y2, int vx1, int vy1,
			int vx2, int vy2, int r1, int r2);
		pair_t p;
		p.first_x = x1;
		p.first_y = y1;
		p.second_x = x2;
		p.second_y = y2;
		p.first_vx = vx1;
		p.first_vy = vy1;
		p.second_vx = vx2;
		p.second_vy = vy2;
		p.first_radius = r1[RADIUS_W-1:0];
		p.second_radius = r2[RADIUS_W-1:0];
		return p;
	endfunction

	function automatic int near_offset();
		int span;
		case ($urandom_range(3))
			0: span = 1 << 10;
			1: span = 1 << 18;
			2: span = 1 << 20;
			default: span = (1 << 21) + 8;
		endcase
		return int'($urandom_range(2 * span)) - span;
	endfunction

	function automatic pair_t random_pair();
		pair_t p;
		int sel;
		sel = $urandom_range(99);
		p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, 8'h0, $urandom};
		p.first_radius = RADIUS_W'($urandom);
		p.second_radius = RADIUS_W'($urandom);
		if (sel >= 15) begin
			// neighbouring pair, most of the stimulus
			p.second_x = p.first_x + near_offset();
			p.second_y = p.first_y + near_offset();
		end
		if (sel >= 92) begin
			p.second_x = p.first_x;
			p.second_y = p.first_y;
		end
		return p;
	endfunction

	task automatic test_directed();
		int rmax;
		rmax = (1 << RADIUS_W) - 1;
		// reset coefficients: spring only
		send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_pair(make_pair(5, 7, 5, 7, 10, -10, 900, 900, 1000, 1000));
		send_pair(make_pair(0, 0, 1 << 19, 0, 0, 0, 0, 0, 1 << 19, 1 << 19));
		send_pair(make_pair(0, 0, 1 << 20, 0, 0, 0, 0, 0, 1 << 19, 1 << 19));
		send_pair(make_pair(0, 0, 1 << 21, 0, 0, 0, 0, 0, rmax, rmax));
		send_pair(make_pair(0, 0, -(1 << 21) + 1, 3, 0, 0, 0, 0, rmax, rmax));
		send_pair(make_pair(100, 100, 300100, -399900, 0, 0, 0, 0, rmax, rmax));
		send_pair(make_pair(32'h7fffffff, 0, 32'h80000000, 0, 0, 0, 0, 0, rmax, rmax));
		send_pair(make_pair(-1, -1, 0, 0, 0, 0, 0, 0, 1, 1));
		set_coefficients('1, '1);
		send_pair(make_pair(0, 0, 1000, -1000, 32'h80000000, 32'h7fffffff,
			32'h7fffffff, 32'h80000000, rmax, rmax));
		send_pair(make_pair(0, 0, 0, 0, 32'h7fffffff, 32'h80000000,
			32'h80000000, 32'h7fffffff, 1, 0));
		send_pair(make_pair(0, 0, 1, 0, 0, 0, 1, -1, rmax, rmax));
		send_pair(make_pair(0, 0, 0, 1 << 20, 0, 0, 0, 0, rmax, rmax));
		set_coefficients('0, 256);
		send_pair(make_pair(0, 0, 4000, 3000, 0, 0, -256, 512, rmax, 0));
		send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
	endtask

	task automatic test_random_phase(int idle, int stall, logic [CFG_W-1:0] k,
			logic [CFG_W-1:0] b, int count);
		set_coefficients(k, b);
		sender_idle_pct = idle;
		receiver_stall_pct = stall;
		repeat (count)
			send_pair(random_pair());
		// some back-to-back traffic to close each phase
		sender_idle_pct = 0;
		repeat (10)
			send_pair(random_pair());
	endtask

	initial begin
		arst_n = 1'b0;
		pair_valid = 1'b0;
		pair = '0;
		reaction_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_SPRING;
		cfg_data = '0;
		stiffness_k = STIFF_RESET;
		damping_k = DAMP_RESET;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		mismatches = 0;
		pairs_sent = 0;
		reactions_seen = 0;
		contacts_seen = 0;
		cycles = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_random_phase(0, 0, '0, '0, 90);
		test_random_phase(53, 0, '1, '1, 90);
		test_random_phase(0, 53, $urandom, $urandom, 90);
		test_random_phase(16, 16, $urandom, $urandom_range(4096), 90);
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		wait_idle();

		$display("%0d pairs sent, %0d forces checked, %0d of them in contact",
			pairs_sent, reactions_seen, contacts_seen);
		$display("coefficient extremes and random values under four idle/stall mixes");
		if (mismatches == 0 && expected_reactions.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// File: files.f
hw/rtl/ssc_pkg.sv
hw/rtl/soft_sphere_contact_force_top.sv
tb/testbench.sv
